FILE: design/rdx_pkg.sv
// shared constants, types and helper functions of the radix digit converter
package rdx_pkg;

   // width of the converted value and worst-case number of digits (radix two)
   localparam int VALUE_BITS = 32;

   localparam int DIGIT_W = 6;
   localparam int CHAR_W  = 7;
   localparam int RADIX_W = 6;

   // conversion counter holds up to 2*VALUE_BITS-1, digit count runs to VALUE_BITS
   localparam int CNT_W = $clog2(2 * VALUE_BITS);
   localparam int REM_W = $clog2(VALUE_BITS + 1);

   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

   localparam logic [DIGIT_W-1:0] DIGIT_TEN = DIGIT_W'(10);
   localparam logic [CHAR_W-1:0]  CHAR_ZERO = CHAR_W'(48);
   localparam logic [CHAR_W-1:0]  CHAR_A    = CHAR_W'(97);

   // controller states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   // controls from the sequencer to the digit array
   typedef struct packed {
      logic                clear;
      logic                bit_vld;
      logic                bit_in;
      logic                shift;
      logic [RADIX_W-1:0]  radix;
   } array_ctrl_type;

   // saturate the register to the supported radix range
   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end else begin
         res = r;
      end
      return res;
   endfunction

   // digit value to lower-case ascii character
   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] res;
      if (d < DIGIT_TEN) begin
         res = CHAR_ZERO + {1'b0, d};
      end else begin
         res = CHAR_A + {1'b0, d - DIGIT_TEN};
      end
      return res;
   endfunction

endpackage

FILE: design/rdx_digit_array.sv
// systolic row of radix digit cells, doubled in a skewed wavefront, then shifted out
module rdx_digit_array (
   input  logic                          clock,
   input  logic                          reset,
   input  rdx_pkg::array_ctrl_type       ctrl,
   output logic [rdx_pkg::DIGIT_W-1:0]   top_digit
);

   localparam int N = rdx_pkg::VALUE_BITS;

   logic [rdx_pkg::DIGIT_W-1:0] cells_ff [N];
   logic [rdx_pkg::DIGIT_W-1:0] cells_in [N];
   logic [N-1:0]                carry_ff;
   logic [N-1:0]                carry_in;
   logic [N-1:0]                vld_ff;
   logic [N-1:0]                vld_in;

   // each cell doubles its digit and adds the carry wave from its lower neighbour
   always_comb begin
      logic                        cin;
      logic                        vin;
      logic [rdx_pkg::DIGIT_W:0]   dbl;
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            cin = ctrl.bit_in;
            vin = ctrl.bit_vld;
         end else begin
            cin = carry_ff[i-1];
            vin = vld_ff[i-1];
         end
         dbl = {cells_ff[i], cin};
         cells_in[i] = cells_ff[i];
         carry_in[i] = 1'b0;
         vld_in[i]   = vin;
         if (ctrl.clear) begin
            cells_in[i] = '0;
            vld_in[i]   = 1'b0;
         end else if (ctrl.shift) begin
            // emission: move every digit one place towards the top
            if (i == 0) begin
               cells_in[i] = '0;
            end else begin
               cells_in[i] = cells_ff[i-1];
            end
            vld_in[i] = 1'b0;
         end else if (vin) begin
            if (dbl >= {1'b0, ctrl.radix}) begin
               cells_in[i] = rdx_pkg::DIGIT_W'(dbl - {1'b0, ctrl.radix});
               carry_in[i] = 1'b1;
            end else begin
               cells_in[i] = rdx_pkg::DIGIT_W'(dbl);
            end
         end
      end
   end

   // wave valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // digit and carry storage
   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
      carry_ff <= carry_in;
   end

   assign top_digit = cells_ff[N-1];

endmodule

FILE: design/int_to_radix_digits_unit.sv
// top level of the radix digit converter: command port, radix register, sequencer
//
// Converts one unsigned value into its digits in the radix held in the radix register
// (values below 2 act as 2, above 36 as 36), as lower-case ascii, most significant
// digit first, with no leading zeros; zero gives the single digit '0'. Pulse start
// while busy is low to hand over a value. The value is shifted in one bit per cycle
// into a row of VALUE_BITS digit cells, and the carry wave ripples one cell per cycle
// up the row. The cells are then shifted out one per cycle, leading zeros being
// dropped, and busy stays high through conversion and emission. Each digit appears on
// the rsp_ ports for one cycle with rsp_valid high and must be taken in that cycle,
// as the receiver cannot stall the block; the final digit carries rsp_last_digit.
// The last digit shows in the cycle busy falls. Write the radix only while idle.
module int_to_radix_digits_unit (
   input  logic                                clock,
   input  logic                                reset,
   // command channel
   input  logic                                start,
   output logic                                busy,
   input  logic [rdx_pkg::VALUE_BITS-1:0]      req_value,
   // result channel
   output logic                                rsp_valid,
   output logic [rdx_pkg::CHAR_W-1:0]          rsp_digit_char,
   output logic                                rsp_last_digit,
   // radix register
   input  logic                                csr_write_en,
   input  logic [rdx_pkg::RADIX_W-1:0]         csr_write_data
);

   localparam int N = rdx_pkg::VALUE_BITS;
   localparam logic [rdx_pkg::CNT_W-1:0] CONV_LAST = rdx_pkg::CNT_W'(2 * N - 2);
   localparam logic [rdx_pkg::CNT_W-1:0] FEED_END  = rdx_pkg::CNT_W'(N);
   localparam logic [rdx_pkg::CNT_W-1:0] CNT_ONE   = rdx_pkg::CNT_W'(1);
   localparam logic [rdx_pkg::REM_W-1:0] REM_FULL  = rdx_pkg::REM_W'(N);
   localparam logic [rdx_pkg::REM_W-1:0] REM_ONE   = rdx_pkg::REM_W'(1);

   rdx_pkg::state_type              state_ff, state_in;
   logic [rdx_pkg::RADIX_W-1:0]     radix_ff;
   logic [rdx_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [rdx_pkg::REM_W-1:0]       rem_ff, rem_in;
   logic                            started_ff, started_in;
   logic [N-1:0]                    val_ff, val_in;
   logic                            strobe_ff, strobe_in;
   logic [rdx_pkg::CHAR_W-1:0]      char_ff, char_in;
   logic                            last_ff, last_in;
   logic                            accept;
   logic [rdx_pkg::DIGIT_W-1:0]     top_digit;
   rdx_pkg::array_ctrl_type         ctrl;

   assign busy   = (state_ff != rdx_pkg::ST_IDLE);
   assign accept = start && !busy;

   // radix register
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= rdx_pkg::RADIX_RESET;
      end else if (csr_write_en) begin
         radix_ff <= csr_write_data;
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      started_in = started_ff;
      val_in     = val_ff;
      strobe_in  = 1'b0;
      char_in    = rdx_pkg::digit_to_ascii(top_digit);
      last_in    = (rem_ff == REM_ONE);
      ctrl.clear   = 1'b0;
      ctrl.bit_vld = 1'b0;
      ctrl.bit_in  = val_ff[N-1];
      ctrl.shift   = 1'b0;
      ctrl.radix   = rdx_pkg::clamp_radix(radix_ff);
      unique case (state_ff)
         rdx_pkg::ST_IDLE: begin
            if (accept) begin
               ctrl.clear = 1'b1;
               val_in     = req_value;
               cnt_in     = '0;
               state_in   = rdx_pkg::ST_CONV;
            end
         end
         rdx_pkg::ST_CONV: begin
            // feed msb first while input bits remain, the wave keeps running after
            ctrl.bit_vld = (cnt_ff < FEED_END);
            val_in       = {val_ff[N-2:0], 1'b0};
            cnt_in       = cnt_ff + CNT_ONE;
            if (cnt_ff == CONV_LAST) begin
               rem_in     = REM_FULL;
               started_in = 1'b0;
               state_in   = rdx_pkg::ST_EMIT;
            end
         end
         rdx_pkg::ST_EMIT: begin
            // drop leading zeros, but always give the least significant digit
            ctrl.shift = 1'b1;
            strobe_in  = started_ff || (top_digit != '0) || (rem_ff == REM_ONE);
            started_in = strobe_in;
            rem_in     = rem_ff - REM_ONE;
            if (rem_ff == REM_ONE) begin
               state_in = rdx_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rdx_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rdx_pkg::ST_IDLE;
         strobe_ff  <= 1'b0;
         cnt_ff     <= '0;
         rem_ff     <= '0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         strobe_ff  <= strobe_in;
         cnt_ff     <= cnt_in;
         rem_ff     <= rem_in;
         started_ff <= started_in;
      end
   end

   // value shifter and result beat
   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   rdx_digit_array u_cells (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .top_digit (top_digit)
   );

   assign rsp_valid      = strobe_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = last_ff;

endmodule
